FILE: hdl/hslc_pkg.sv
// Shared widths, constants and types of the HSL to RGB converter.
package hslc_pkg;

	// Field widths
	localparam int HUE_W  = 9;
	localparam int PCT_W  = 7;
	localparam int CHAN_W = 8;

	// Internal widths: fraction numerators in units of 1/600000, scaled numerators
	localparam int AS_W  = 14;
	localparam int FRAC_W = 6;
	localparam int V_W   = 20;
	localparam int N_W   = 24;
	localparam int PROD_W = N_W + 17;

	// Range limits and sector geometry
	localparam logic [HUE_W-1:0] HUE_TURN   = 9'd360;
	localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
	localparam logic [PCT_W-1:0] PCT_HALF   = 7'd50;
	localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;

	// Channel scaling: v * 255 / 600000 == (v * 17) / 40000
	localparam logic [V_W-1:0]  M_SCALE   = 20'd6000;
	localparam logic [V_W-1:0]  HALF_C    = 20'd30;
	localparam logic [V_W-1:0]  FULL_C    = 20'd60;
	localparam logic [N_W-1:0]  CHAN_NUM  = 24'd17;
	localparam logic [N_W-1:0]  DIV_DEN   = 24'd40000;
	// floor(2^32 / 40000); the estimate is low by at most one
	localparam logic [16:0]     RECIP_M   = 17'd107374;
	localparam int              RECIP_SHIFT = 32;

	typedef enum logic [2:0] {
		SEC_RY,
		SEC_YG,
		SEC_GC,
		SEC_CB,
		SEC_BM,
		SEC_MR
	} sector_t;

	// Chroma terms and control leaving the front stages
	typedef struct packed {
		logic            valid;
		logic            err;
		sector_t         sector;
		logic [V_W-1:0]  cn;
		logic [V_W-1:0]  xn;
		logic [V_W-1:0]  mn;
	} terms_t;

endpackage

FILE: hdl/hsl_pixel_if.sv
// Input channel carrying one HSL pixel with a valid/ready handshake.
interface hsl_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [hslc_pkg::HUE_W-1:0]  hue;
	logic [hslc_pkg::PCT_W-1:0]  saturation;
	logic [hslc_pkg::PCT_W-1:0]  lightness;

	modport source(output valid, hue, saturation, lightness, input ready);
	modport sink(input valid, hue, saturation, lightness, output ready);
endinterface

FILE: hdl/rgb_pixel_if.sv
// Output channel carrying one RGB pixel and its range flag with a valid/ready handshake.
interface rgb_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [hslc_pkg::CHAN_W-1:0]  red;
	logic [hslc_pkg::CHAN_W-1:0]  green;
	logic [hslc_pkg::CHAN_W-1:0]  blue;
	logic                         range_error;

	modport source(output valid, red, green, blue, range_error, input ready);
	modport sink(input valid, red, green, blue, range_error, output ready);
endinterface

FILE: hdl/hslc_prep.sv
// Front stages: range check, sector decode, chroma product and the C, X, m terms.
module hslc_prep (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [hslc_pkg::HUE_W-1:0]  hue,
	input  logic [hslc_pkg::PCT_W-1:0]  saturation,
	input  logic [hslc_pkg::PCT_W-1:0]  lightness,
	output hslc_pkg::terms_t            terms
);

	logic                          err;
	logic [hslc_pkg::HUE_W-1:0]    h_w;
	logic [hslc_pkg::HUE_W-1:0]    h_m;
	logic [hslc_pkg::FRAC_W-1:0]   f;
	logic [hslc_pkg::PCT_W-1:0]    s_c;
	logic [hslc_pkg::PCT_W-1:0]    l_c;
	logic [hslc_pkg::PCT_W-1:0]    a;
	hslc_pkg::sector_t             sec;

	logic                          v_s1, v_s2, v_s3;
	logic                          err_s1, err_s2, err_s3;
	hslc_pkg::sector_t             sec_s1, sec_s2, sec_s3;
	logic [hslc_pkg::PCT_W-1:0]    a_s1, s_s1, l_s1, l_s2;
	logic [hslc_pkg::FRAC_W-1:0]   f_s1, f_s2;
	logic [hslc_pkg::AS_W-1:0]     as_s2;
	logic [hslc_pkg::V_W-1:0]      cn_s3, xn_s3, mn_s3;

	// Check range, wrap hue, find sector and the X fraction
	always_comb begin
		err = (hue > hslc_pkg::HUE_TURN) || (saturation > hslc_pkg::PCT_MAX) ||
			(lightness > hslc_pkg::PCT_MAX);
		h_w = (hue == hslc_pkg::HUE_TURN) ? '0 : hue;
		s_c = err ? '0 : saturation;
		l_c = err ? '0 : lightness;
		if (h_w < hslc_pkg::SECTOR_DEG) begin
			sec = hslc_pkg::SEC_RY;
		end else if (h_w < 9'(2 * hslc_pkg::SECTOR_DEG)) begin
			sec = hslc_pkg::SEC_YG;
		end else if (h_w < 9'(3 * hslc_pkg::SECTOR_DEG)) begin
			sec = hslc_pkg::SEC_GC;
		end else if (h_w < 9'(4 * hslc_pkg::SECTOR_DEG)) begin
			sec = hslc_pkg::SEC_CB;
		end else if (h_w < 9'(5 * hslc_pkg::SECTOR_DEG)) begin
			sec = hslc_pkg::SEC_BM;
		end else begin
			sec = hslc_pkg::SEC_MR;
		end
		// hue mod 120
		if (h_w >= 9'(4 * hslc_pkg::SECTOR_DEG)) begin
			h_m = h_w - 9'(4 * hslc_pkg::SECTOR_DEG);
		end else if (h_w >= 9'(2 * hslc_pkg::SECTOR_DEG)) begin
			h_m = h_w - 9'(2 * hslc_pkg::SECTOR_DEG);
		end else begin
			h_m = h_w;
		end
		// 60 - |hue mod 120 - 60|
		if (h_m >= hslc_pkg::SECTOR_DEG) begin
			f = 6'(9'(2 * hslc_pkg::SECTOR_DEG) - h_m);
		end else begin
			f = 6'(h_m);
		end
		// 100 - |2L - 100|
		if (l_c >= hslc_pkg::PCT_HALF) begin
			a = 7'(8'(2 * hslc_pkg::PCT_MAX) - {l_c, 1'b0});
		end else begin
			a = {l_c[5:0], 1'b0};
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Advance payload: decode, product a*S, then C, X and m
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= err;
			sec_s1 <= sec;
			a_s1   <= a;
			s_s1   <= s_c;
			l_s1   <= l_c;
			f_s1   <= f;

			err_s2 <= err_s1;
			sec_s2 <= sec_s1;
			as_s2  <= hslc_pkg::AS_W'(a_s1) * hslc_pkg::AS_W'(s_s1);
			l_s2   <= l_s1;
			f_s2   <= f_s1;

			err_s3 <= err_s2;
			sec_s3 <= sec_s2;
			cn_s3  <= 20'(as_s2) * hslc_pkg::FULL_C;
			xn_s3  <= 20'(as_s2) * 20'(f_s2);
			mn_s3  <= 20'(l_s2) * hslc_pkg::M_SCALE - 20'(as_s2) * hslc_pkg::HALF_C;
		end
	end

	assign terms.valid  = v_s3;
	assign terms.err    = err_s3;
	assign terms.sector = sec_s3;
	assign terms.cn     = cn_s3;
	assign terms.xn     = xn_s3;
	assign terms.mn     = mn_s3;

endmodule

FILE: hdl/hslc_div.sv
// Two-stage divide by 40000 through a reciprocal multiply and one correction step.
module hslc_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hslc_pkg::N_W-1:0]    num,
	output logic [hslc_pkg::CHAN_W-1:0] quo
);

	logic [hslc_pkg::PROD_W-1:0]  prod;
	logic [hslc_pkg::N_W-1:0]     rem;
	logic [hslc_pkg::N_W-1:0]     n_s5;
	logic [hslc_pkg::CHAN_W-1:0]  q_s5;
	logic [hslc_pkg::CHAN_W-1:0]  q_s6;

	// Estimate quotient, low by at most one
	assign prod = hslc_pkg::PROD_W'(num) * hslc_pkg::PROD_W'(hslc_pkg::RECIP_M);

	// Remainder of the estimate
	assign rem = n_s5 - 24'(q_s5) * hslc_pkg::DIV_DEN;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5 <= num;
			q_s5 <= prod[hslc_pkg::RECIP_SHIFT +: hslc_pkg::CHAN_W];
			q_s6 <= (rem >= hslc_pkg::DIV_DEN) ? q_s5 + 8'd1 : q_s5;
		end
	end

	assign quo = q_s6;

endmodule

FILE: hdl/hsl_to_rgb_converter_top.sv
// Top level of the HSL to RGB converter: front stages, channel mux and three dividers.
//
//  channel  dir  handshake         payload
//  hsl      in   valid / ready     hue[8:0], saturation[6:0], lightness[6:0]
//  rgb      out  valid / ready     red[7:0], green[7:0], blue[7:0], range_error
//
//  One pixel is taken every cycle while the output is not stalled. The depth is
//  set by the decode register, the a*S product, the C/X/m terms, the scale by 17
//  and the two-stage reciprocal divide. The whole pipeline advances together:
//  while rgb holds an untaken result, hsl.ready is low and every stage holds.
//  Reset clears the valid bits only.
module hsl_to_rgb_converter_top (
	input  logic               clk,
	input  logic               arst_n,
	hsl_pixel_if.sink          hsl,
	rgb_pixel_if.source        rgb
);

	logic                          adv;
	hslc_pkg::terms_t              terms;
	logic [hslc_pkg::V_W-1:0]      vr, vg, vb;
	logic [hslc_pkg::V_W-1:0]      sr, sg, sb;
	logic [hslc_pkg::N_W-1:0]      nr_s4, ng_s4, nb_s4;
	logic                          v_s4, v_s5, v_s6;
	logic                          err_s4, err_s5, err_s6;

	// Advance whenever the output stage is empty or being taken
	assign adv       = !v_s6 || rgb.ready;
	assign hsl.ready = adv;

	hslc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (hsl.valid),
		.hue        (hsl.hue),
		.saturation (hsl.saturation),
		.lightness  (hsl.lightness),
		.terms      (terms)
	);

	// Place C and X on the channels by sector
	always_comb begin
		vr = '0;
		vg = '0;
		vb = '0;
		unique case (terms.sector)
			hslc_pkg::SEC_RY: begin vr = terms.cn; vg = terms.xn; end
			hslc_pkg::SEC_YG: begin vr = terms.xn; vg = terms.cn; end
			hslc_pkg::SEC_GC: begin vg = terms.cn; vb = terms.xn; end
			hslc_pkg::SEC_CB: begin vg = terms.xn; vb = terms.cn; end
			hslc_pkg::SEC_BM: begin vr = terms.xn; vb = terms.cn; end
			hslc_pkg::SEC_MR: begin vr = terms.cn; vb = terms.xn; end
			default:          begin vr = terms.cn; vb = terms.xn; end
		endcase
		sr = vr + terms.mn;
		sg = vg + terms.mn;
		sb = vb + terms.mn;
	end

	// Scale by 17 ahead of the divide by 40000
	always_ff @(posedge clk) begin
		if (adv) begin
			nr_s4  <= 24'(sr) * hslc_pkg::CHAN_NUM;
			ng_s4  <= 24'(sg) * hslc_pkg::CHAN_NUM;
			nb_s4  <= 24'(sb) * hslc_pkg::CHAN_NUM;
			err_s4 <= terms.err;
			err_s5 <= err_s4;
			err_s6 <= err_s5;
		end
	end

	// Carry valid bits through the back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s4 <= terms.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	hslc_div u_div_r (.clk(clk), .en(adv), .num(nr_s4), .quo(rgb.red));
	hslc_div u_div_g (.clk(clk), .en(adv), .num(ng_s4), .quo(rgb.green));
	hslc_div u_div_b (.clk(clk), .en(adv), .num(nb_s4), .quo(rgb.blue));

	assign rgb.valid       = v_s6;
	assign rgb.range_error = err_s6;

	// A flagged pixel comes out black
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		rgb.valid && rgb.range_error |-> rgb.red == '0 && rgb.green == '0 && rgb.blue == '0)
		else $error("range error pixel not black");

	// Input is refused only while a result waits on the output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl.ready |-> rgb.valid && !rgb.ready)
		else $error("input stalled without output backpressure");

	// An item in the first divide stage reaches the output on the next advance
	a_s5_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s5 |=> rgb.valid)
		else $error("item lost between divide stages");

	// A held result keeps its flag
	a_hold_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rgb.valid && !rgb.ready |=> $stable(rgb.range_error) && rgb.valid)
		else $error("stalled result changed");

endmodule
